FILE: hw/rtl/hng_pkg.sv
package hng_pkg;

  // fixed field widths
  localparam int unsigned IndexW = 14;
  localparam int unsigned ValueW = 63;

  // multiplier codes for the shared shift-add unit
  typedef enum logic [1:0] {
    SCALE_2,
    SCALE_3,
    SCALE_5
  } scale_e;

  typedef logic [ValueW-1:0] value_t;

endpackage

FILE: hw/rtl/hng_scale.sv
module hng_scale import hng_pkg::*; (
  input  value_t operand_i,
  input  scale_e op_i,
  input  value_t min_i,
  output value_t product_o,
  output logic   less_o
);

  logic [ValueW+2:0] shifted;
  logic [ValueW+2:0] addend;
  logic [ValueW+2:0] sum;

  // 2x = x<<1, 3x = (x<<1)+x, 5x = (x<<2)+x
  always_comb begin
    case (op_i)
      SCALE_2: begin
        shifted = {2'b00, operand_i, 1'b0};
        addend  = '0;
      end
      SCALE_3: begin
        shifted = {2'b00, operand_i, 1'b0};
        addend  = {3'b000, operand_i};
      end
      SCALE_5: begin
        shifted = {1'b0, operand_i, 2'b00};
        addend  = {3'b000, operand_i};
      end
      default: begin
        shifted = '0;
        addend  = '0;
      end
    endcase
  end

  assign sum = shifted + addend;

  // saturate at the largest 63-bit value
  assign product_o = (sum[ValueW+2:ValueW] != 3'b000) ? '1 : sum[ValueW-1:0];
  assign less_o    = product_o < min_i;

endmodule

FILE: hw/rtl/hng_table.sv
module hng_table import hng_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 8192,
  localparam int unsigned AddrW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1
) (
  input  logic             clk_i,
  input  logic             wr_en_i,
  input  logic [AddrW-1:0] wr_addr_i,
  input  value_t           wr_data_i,
  input  logic [AddrW-1:0] rd_addr_i,
  output value_t           rd_data_o
);

  value_t mem [TABLE_DEPTH];
  value_t rd_data_q;
  logic   rd_zero_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    rd_data_q <= mem[rd_addr_i];
    rd_zero_q <= (rd_addr_i == '0);
  end

  // entry zero is fixed at one and never written
  assign rd_data_o = rd_zero_q ? value_t'(1) : rd_data_q;

endmodule

FILE: hw/rtl/hamming_number_generator.sv
// channel   | handshake                     | payload
// ----------+-------------------------------+--------------------------
// request   | in_valid_i  / in_stall_o      | index_i (14b)
// result    | out_valid_o / out_stall_i     | value_o (63b), bad_index_o
//
// a request whose entry is already in the table is read in the lookup and lookup-wait
// steps, and the next request can be taken once the done step has passed its result on
// each table entry that must be added first takes the steps RD2, RD3, RD5, LAST and
// WRITE: three reads through the single read port of the table, each scaled by the
// shared shift-add unit, the first product setting the running minimum and the other
// two compared against it, then one write; an invalid index skips to the done step
// reset leaves only entry zero known (held as the constant one), all pointers at zero
// the result register frees the request side: a new request is taken while the
// last result is still stalled, and its result waits until that one is taken
module hamming_number_generator import hng_pkg::*; #(
  parameter int unsigned TABLE_DEPTH = 8192
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [IndexW-1:0] index_i,
  output logic              out_valid_o,
  input  logic              out_stall_i,
  output value_t            value_o,
  output logic              bad_index_o
);

  localparam int unsigned AddrW  = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
  localparam int unsigned CountW = $clog2(TABLE_DEPTH + 1);
  localparam logic [IndexW:0] DepthW = (IndexW+1)'(TABLE_DEPTH);

  typedef enum logic [3:0] {
    S_IDLE,
    S_RD2,
    S_RD3,
    S_RD5,
    S_LAST,
    S_WRITE,
    S_LOOK,
    S_LOOKW,
    S_DONE
  } state_e;

  state_e state_q;

  // table bookkeeping
  logic [CountW-1:0] filled_q;
  logic [AddrW-1:0]  ptr2_q, ptr3_q, ptr5_q;

  // request being served
  logic [IndexW-1:0] idx_q;
  logic [IndexW-1:0] idx_m1;

  // candidate products and running minimum
  value_t prod2_q, prod3_q, prod5_q, min_q;

  // result staging and output register
  value_t res_val_q;
  logic   res_bad_q;
  logic   out_valid_q;
  value_t value_q;
  logic   bad_q;

  // shared unit and table ports
  scale_e           scale_op;
  value_t           scale_prod;
  logic             scale_less;
  value_t           rd_data;
  logic [AddrW-1:0] rd_addr;
  logic             wr_en;

  logic in_bad;
  logic need_more;
  logic need_next;
  logic [IndexW:0] filled_ext;

  assign idx_m1     = idx_q - IndexW'(1);
  assign filled_ext = (IndexW+1)'(filled_q);
  assign in_bad     = (index_i == '0) || ({1'b0, index_i} > DepthW);
  assign need_more  = filled_ext < {1'b0, index_i};
  // after this write the count grows by one
  assign need_next  = (filled_ext + (IndexW+1)'(1)) < {1'b0, idx_q};

  // read address and multiplier follow the sequencer step
  always_comb begin
    rd_addr  = ptr2_q;
    scale_op = SCALE_2;
    case (state_q)
      S_RD2:   rd_addr = ptr2_q;
      S_RD3: begin
        rd_addr  = ptr3_q;
        scale_op = SCALE_2;
      end
      S_RD5: begin
        rd_addr  = ptr5_q;
        scale_op = SCALE_3;
      end
      S_LAST:  scale_op = SCALE_5;
      S_LOOK:  rd_addr = idx_m1[AddrW-1:0];
      default: begin
        rd_addr  = ptr2_q;
        scale_op = SCALE_2;
      end
    endcase
  end

  assign wr_en = (state_q == S_WRITE);

  hng_scale u_scale (
    .operand_i (rd_data),
    .op_i      (scale_op),
    .min_i     (min_q),
    .product_o (scale_prod),
    .less_o    (scale_less)
  );

  hng_table #(
    .TABLE_DEPTH (TABLE_DEPTH)
  ) u_table (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (filled_q[AddrW-1:0]),
    .wr_data_i (min_q),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      filled_q    <= CountW'(1);
      ptr2_q      <= '0;
      ptr3_q      <= '0;
      ptr5_q      <= '0;
      idx_q       <= '0;
      prod2_q     <= '0;
      prod3_q     <= '0;
      prod5_q     <= '0;
      min_q       <= '0;
      res_val_q   <= '0;
      res_bad_q   <= 1'b0;
      out_valid_q <= 1'b0;
      value_q     <= '0;
      bad_q       <= 1'b0;
    end else begin
      // result register drains independently of the sequencer,
      // except when the done step reloads it in the same cycle
      if (out_valid_q && !out_stall_i && (state_q != S_DONE)) begin
        out_valid_q <= 1'b0;
      end
      case (state_q)
        S_IDLE: begin
          if (in_valid_i) begin
            idx_q <= index_i;
            if (in_bad) begin
              res_val_q <= '0;
              res_bad_q <= 1'b1;
              state_q   <= S_DONE;
            end else if (need_more) begin
              state_q <= S_RD2;
            end else begin
              state_q <= S_LOOK;
            end
          end
        end
        S_RD2:   state_q <= S_RD3;
        S_RD3: begin
          prod2_q <= scale_prod;
          min_q   <= scale_prod;
          state_q <= S_RD5;
        end
        S_RD5: begin
          prod3_q <= scale_prod;
          if (scale_less) begin
            min_q <= scale_prod;
          end
          state_q <= S_LAST;
        end
        S_LAST: begin
          prod5_q <= scale_prod;
          if (scale_less) begin
            min_q <= scale_prod;
          end
          state_q <= S_WRITE;
        end
        S_WRITE: begin
          // every pointer that produced the minimum moves on, so no duplicates
          filled_q <= filled_q + CountW'(1);
          if (prod2_q == min_q) ptr2_q <= ptr2_q + AddrW'(1);
          if (prod3_q == min_q) ptr3_q <= ptr3_q + AddrW'(1);
          if (prod5_q == min_q) ptr5_q <= ptr5_q + AddrW'(1);
          state_q <= need_next ? S_RD2 : S_LOOK;
        end
        S_LOOK:  state_q <= S_LOOKW;
        S_LOOKW: begin
          res_val_q <= rd_data;
          res_bad_q <= 1'b0;
          state_q   <= S_DONE;
        end
        S_DONE: begin
          if (!out_valid_q || !out_stall_i) begin
            out_valid_q <= 1'b1;
            value_q     <= res_val_q;
            bad_q       <= res_bad_q;
            state_q     <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase
    end
  end

  assign in_stall_o  = (state_q != S_IDLE);
  assign out_valid_o = out_valid_q;
  assign value_o     = value_q;
  assign bad_index_o = bad_q;

  // table never grows past its depth
  a_filled_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (IndexW+1)'(filled_q) <= DepthW)
    else $error("fill count beyond table depth");

  // pointers only ever address entries already written
  a_ptr_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (CountW'(ptr2_q) < filled_q) && (CountW'(ptr3_q) < filled_q)
    && (CountW'(ptr5_q) < filled_q))
    else $error("pointer reaches unwritten entry");

  // the minimum always comes from at least one candidate
  a_ptr_moves: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_WRITE) |-> ((prod2_q == min_q) || (prod3_q == min_q)
    || (prod5_q == min_q)))
    else $error("no pointer advances on write");

  // lookup starts only once the requested entry exists
  a_look_filled: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_LOOK) |-> ((IndexW+1)'(filled_q) >= {1'b0, idx_q}))
    else $error("lookup before table is long enough");

endmodule
